@@ hdl/mfhd_pkg.sv @@
// ----------------------------------------------------------------------------
// mfhd_pkg
// Beat types and result kind codes for the fixed-header deframer.
// ----------------------------------------------------------------------------
package mfhd_pkg;

    localparam int unsigned LEN_W = 28;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_HEADER    = 2'd0;
    localparam kind_t KIND_BODY      = 2'd1;
    localparam kind_t KIND_TOO_LONG  = 2'd2;
    localparam kind_t KIND_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_last;
    } in_beat_t;

    typedef struct packed {
        kind_t            result_kind;
        logic [3:0]       packet_type;
        logic [3:0]       packet_flags;
        logic [LEN_W-1:0] remaining_length;
        logic [7:0]       body_byte;
        logic             packet_last;
    } out_beat_t;

endpackage

@@ hdl/mfhd_core.sv @@
// ----------------------------------------------------------------------------
// mfhd_core
// Per-byte header/length/body decode; one byte per accepted beat.
// ----------------------------------------------------------------------------
module mfhd_core
    import mfhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_beat_t  beat,
    output logic      res_valid,
    output out_beat_t res
);

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_BODY   = 4'b0100,
        PH_IGNORE = 4'b1000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [7:0]       tf_reg, tf_next;
    logic [LEN_W-1:0] acc_reg, acc_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0] left_reg, left_next;

    logic [LEN_W-1:0] addend;
    logic [LEN_W-1:0] acc_sum;
    logic [LEN_W-1:0] left_dec;
    logic [7:0]       b;
    logic             last;

    assign b        = beat.data_byte;
    assign last     = beat.buffer_last;
    assign left_dec = left_reg - LEN_W'(1);
    assign acc_sum  = acc_reg + addend;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    addend = LEN_W'(b[6:0]);
            2'd1:    addend = LEN_W'(b[6:0]) << 7;
            2'd2:    addend = LEN_W'(b[6:0]) << 14;
            default: addend = LEN_W'(b[6:0]) << 21;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        tf_next    = tf_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        res_valid  = 1'b0;
        res.result_kind = KIND_HEADER;
        res.body_byte   = 8'd0;
        res.packet_last = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_FIRST:
                begin
                    tf_next   = b;
                    acc_next  = '0;
                    cnt_next  = '0;
                    left_next = '0;
                    if (last)
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_TRUNCATED;
                        phase_next      = PH_FIRST;
                    end
                    else
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    if (cnt_reg[2])
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_TOO_LONG;
                        phase_next      = last ? PH_FIRST : PH_IGNORE;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                        cnt_next = cnt_reg + 3'd1;
                        if (b[7])
                        begin
                            if (last)
                            begin
                                res_valid       = 1'b1;
                                res.result_kind = KIND_TRUNCATED;
                                phase_next      = PH_FIRST;
                            end
                        end
                        else if (acc_sum == '0)
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_HEADER;
                            res.packet_last = 1'b1;
                            phase_next      = last ? PH_FIRST : PH_IGNORE;
                        end
                        else if (last)
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_TRUNCATED;
                            phase_next      = PH_FIRST;
                        end
                        else
                        begin
                            left_next       = acc_sum;
                            res_valid       = 1'b1;
                            res.result_kind = KIND_HEADER;
                            phase_next      = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    left_next = left_dec;
                    res_valid = 1'b1;
                    if (left_dec == '0)
                    begin
                        res.result_kind = KIND_BODY;
                        res.body_byte   = b;
                        res.packet_last = 1'b1;
                        phase_next      = last ? PH_FIRST : PH_IGNORE;
                    end
                    else if (last)
                    begin
                        res.result_kind = KIND_TRUNCATED;
                        phase_next      = PH_FIRST;
                    end
                    else
                    begin
                        res.result_kind = KIND_BODY;
                        res.body_byte   = b;
                    end
                end
                default:
                begin
                    if (last)
                    begin
                        phase_next = PH_FIRST;
                    end
                end
            endcase
        end

        res.packet_type      = tf_next[7:4];
        res.packet_flags     = tf_next[3:0];
        res.remaining_length = acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            tf_reg    <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tf_reg    <= tf_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
        end
    end

endmodule

@@ hdl/mfhd_out_buf.sv @@
// ----------------------------------------------------------------------------
// mfhd_out_buf
// Result register with one skid entry; decouples upstream ready from out_ready.
// ----------------------------------------------------------------------------
module mfhd_out_buf
    import mfhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_beat_t push_data,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      main_v_reg, main_v_next;
    logic      skid_v_reg, skid_v_next;
    out_beat_t main_reg, main_next;
    out_beat_t skid_reg, skid_next;
    logic      pop;

    assign space     = !skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;
    assign pop       = main_v_reg && out_ready;

    always_comb
    begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (skid_v_reg)
        begin
            if (pop)
            begin
                main_next   = skid_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_v_reg || pop)
            begin
                main_next   = push_data;
                main_v_next = 1'b1;
            end
            else
            begin
                skid_next   = push_data;
                skid_v_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ hdl/mqtt_fixed_header_deframer_top.sv @@
// ----------------------------------------------------------------------------
// mqtt_fixed_header_deframer_top
// Byte-wise fixed-header deframer: type/flags, base-128 length, body bytes.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------
//   in      | in_valid / in_ready  | in_data  (in_beat_t)
//   out     | out_valid / out_ready| out_data (out_beat_t)
//
// One byte accepted per cycle while in_ready is high; results are registered.
// The decode state updates in the accept cycle with a single shift-add or
// decrement. Reset returns to waiting for a first header byte.
// in_ready drops only while both the result register and skid entry are full.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_deframer_top
    import mfhd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    logic      accept;
    logic      res_valid;
    out_beat_t res;
    logic      space;

    assign in_ready = space;
    assign accept   = in_valid && space;

    mfhd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .beat      (in_data),
        .res_valid (res_valid),
        .res       (res)
    );

    mfhd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
